>>> src/mtd_pkg.sv
// Shared types and constants for the missing-tooth crank trigger decoder.
// No dependencies; imported by every module of the block.
package mtd_pkg;

    localparam int TS_W        = 32;
    localparam int INDEX_W     = 16;
    localparam int EVENTS_W    = 13;
    localparam int RATIO_W     = 16;
    localparam int RATIO_FRAC  = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int FAULT_LIMIT = 4;

    localparam logic [INDEX_W-1:0] INDEX_MAX = '1;

    typedef enum logic [1:0] {
        EDGE_PRI_RISE = 2'd0,
        EDGE_PRI_FALL = 2'd1,
        EDGE_SEC_RISE = 2'd2,
        EDGE_SEC_FALL = 2'd3
    } t_edge_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_USE_RISING   = 3'd0,
        CFG_SINGLE_TOOTH = 3'd1,
        CFG_EVENTS       = 3'd2,
        CFG_GAP_LOW      = 3'd3,
        CFG_GAP_HIGH     = 3'd4
    } t_cfg_reg;

    localparam logic                RST_USE_RISING   = 1'b1;
    localparam logic                RST_SINGLE_TOOTH = 1'b0;
    localparam logic [EVENTS_W-1:0] RST_EVENTS       = 13'd116;
    localparam logic [RATIO_W-1:0]  RST_GAP_LOW      = 16'd384;
    localparam logic [RATIO_W-1:0]  RST_GAP_HIGH     = 16'd768;

    typedef struct packed {
        logic                use_rising;
        logic                single_tooth;
        logic [EVENTS_W-1:0] events_per_cycle;
        logic [RATIO_W-1:0]  gap_low;
        logic [RATIO_W-1:0]  gap_high;
    } t_cfg;

    typedef struct packed {
        logic [1:0]      kind;
        logic [TS_W-1:0] timestamp;
    } t_item;

endpackage

>>> src/mtd_cfg_regs.sv
// Configuration register file of the trigger decoder.
// Depends on mtd_pkg for register indexes, reset values and t_cfg.
module mtd_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mtd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mtd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output mtd_pkg::t_cfg                  o_cfg
);
    import mtd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_USE_RISING:   n_cfg.use_rising       = i_cfg_data[0];
                CFG_SINGLE_TOOTH: n_cfg.single_tooth     = i_cfg_data[0];
                CFG_EVENTS:       n_cfg.events_per_cycle = i_cfg_data[EVENTS_W-1:0];
                CFG_GAP_LOW:      n_cfg.gap_low          = i_cfg_data[RATIO_W-1:0];
                CFG_GAP_HIGH:     n_cfg.gap_high         = i_cfg_data[RATIO_W-1:0];
                default:          n_cfg = r_cfg;  // unknown index: dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.use_rising       <= RST_USE_RISING;
            r_cfg.single_tooth     <= RST_SINGLE_TOOTH;
            r_cfg.events_per_cycle <= RST_EVENTS;
            r_cfg.gap_low          <= RST_GAP_LOW;
            r_cfg.gap_high         <= RST_GAP_HIGH;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

>>> src/mtd_in_stage.sv
// Input register of the trigger decoder: captures one edge event per cycle while o_in_stall is low.
// Depends on mtd_pkg for t_item.
module mtd_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [1:0]       i_edge_kind,
    input  logic [31:0]      i_timestamp,
    input  logic             i_adv,
    output logic             o_valid,
    output mtd_pkg::t_item   o_item
);
    import mtd_pkg::*;

    logic  r_valid;
    t_item r_item;

    // hold while the decode stage cannot take the held event
    assign o_in_stall = r_valid && !i_adv;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_item.kind      <= i_edge_kind;
            r_item.timestamp <= i_timestamp;
        end
    end

endmodule

>>> src/mtd_decode.sv
// Decode stage: tooth tracking state, gap test, cycle check and result register.
// Depends on mtd_pkg for t_cfg, t_item, edge codes and constants.
module mtd_decode #(
    parameter int ERROR_WINDOW = 6,
    parameter int TIME_BITS    = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mtd_pkg::t_cfg                i_cfg,
    input  logic                         i_valid,
    input  mtd_pkg::t_item               i_item,
    output logic                         o_adv,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_synchronized,
    output logic [mtd_pkg::INDEX_W-1:0]  o_position_index,
    output logic                         o_cycle_start,
    output logic                         o_cycle_error,
    output logic                         o_decoder_fault
);
    import mtd_pkg::*;

    localparam int TSW = (TIME_BITS < TS_W) ? TIME_BITS : TS_W;
    localparam int PW  = TIME_BITS + RATIO_W;

    // tracking state
    logic                    r_sync;
    logic [INDEX_W-1:0]      r_index;
    logic [TIME_BITS-1:0]    r_last_time;
    logic [TIME_BITS-1:0]    r_last_period;
    logic [ERROR_WINDOW-1:0] r_hist;

    logic                    n_sync;
    logic [INDEX_W-1:0]      n_index;
    logic [TIME_BITS-1:0]    n_last_time;
    logic [TIME_BITS-1:0]    n_last_period;
    logic [ERROR_WINDOW-1:0] n_hist;

    // result register
    logic               r_out_valid;
    logic               r_synchronized;
    logic [INDEX_W-1:0] r_position_index;
    logic               r_cycle_start;
    logic               r_cycle_error;
    logic               r_decoder_fault;

    logic                 take;
    logic [EVENTS_W-1:0]  expected_last;
    logic                 at_last;
    logic                 primary;
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] period;
    logic [PW-1:0]        period_scaled;
    logic [PW-1:0]        bound_low;
    logic [PW-1:0]        bound_high;
    logic                 gap;
    logic                 sync_now;
    logic                 start;
    logic                 err;
    logic [INDEX_W-1:0]   index_inc;

    assign o_adv = !r_out_valid || !i_out_stall;
    assign take  = i_valid && o_adv;

    assign expected_last = i_cfg.events_per_cycle - EVENTS_W'(1);
    assign at_last       = (r_index == INDEX_W'(expected_last));
    assign primary       = i_cfg.use_rising ? (i_item.kind == EDGE_PRI_RISE)
                                            : (i_item.kind == EDGE_PRI_FALL);

    assign now    = TIME_BITS'(i_item.timestamp[TSW-1:0]);
    assign period = now - r_last_time;

    // exact Q8.8 gap window: lo*prev < period*256 < hi*prev
    assign period_scaled = PW'(period) << RATIO_FRAC;
    assign bound_low     = PW'(r_last_period) * PW'(i_cfg.gap_low);
    assign bound_high    = PW'(r_last_period) * PW'(i_cfg.gap_high);
    assign gap           = (period_scaled > bound_low) && (period_scaled < bound_high);

    assign sync_now  = i_cfg.single_tooth ? (!r_sync || at_last) : gap;
    assign start     = primary && sync_now;
    assign err       = start && !at_last;
    assign index_inc = (r_index == INDEX_MAX) ? r_index : r_index + INDEX_W'(1);

    always_comb begin
        n_sync        = r_sync;
        n_index       = index_inc;
        n_last_time   = r_last_time;
        n_last_period = r_last_period;
        n_hist        = r_hist;
        if (primary) begin
            n_last_time   = now;
            n_last_period = period;
        end
        if (start) begin
            n_sync  = 1'b1;
            n_index = '0;
            n_hist  = ERROR_WINDOW'({r_hist, err});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync        <= 1'b0;
            r_index       <= '0;
            r_last_time   <= '0;
            r_last_period <= '0;
            r_hist        <= '0;
        end else if (take) begin
            r_sync        <= n_sync;
            r_index       <= n_index;
            r_last_time   <= n_last_time;
            r_last_period <= n_last_period;
            r_hist        <= n_hist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_adv) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_synchronized   <= n_sync;
            r_position_index <= n_index;
            r_cycle_start    <= start;
            r_cycle_error    <= err;
            r_decoder_fault  <= ($countones(n_hist) > FAULT_LIMIT);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_synchronized   = r_synchronized;
    assign o_position_index = r_position_index;
    assign o_cycle_start    = r_cycle_start;
    assign o_cycle_error    = r_cycle_error;
    assign o_decoder_fault  = r_decoder_fault;

    a_err_needs_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_cycle_error |-> r_cycle_start)
        else $error("cycle error reported without a cycle start");

    a_start_clears_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_cycle_start |-> (r_position_index == '0) && r_synchronized)
        else $error("cycle start with nonzero index or unsynchronized");

    a_sync_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sync |=> r_sync)
        else $error("sync flag dropped without reset");

    a_index_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_index == INDEX_MAX |=> (r_index == INDEX_MAX) || (r_index == '0))
        else $error("tooth index wrapped past its maximum");

    a_state_holds_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !take |=> $stable(r_index) && $stable(r_hist) && $stable(r_last_time))
        else $error("tracking state changed without a transaction");

endmodule

>>> src/missing_tooth_trigger_decoder.sv
// Top level of the missing-tooth crank trigger decoder.
// Depends on mtd_pkg, mtd_cfg_regs, mtd_in_stage and mtd_decode.
//
//   channel | direction | handshake                    | payload
//   --------+-----------+------------------------------+--------------------------------
//   in      | in        | i_in_valid / o_in_stall      | i_edge_kind, i_timestamp
//   out     | out       | o_out_valid / i_out_stall    | o_synchronized, o_position_index,
//           |           |                              | o_cycle_start, o_cycle_error,
//           |           |                              | o_decoder_fault
//   cfg     | in        | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// One event per cycle sustained while i_out_stall is low; an event passes the input register,
// then the result register, which presents its result until accepted. The period subtract,
// one 32x16 product per gap bound and the compares sit in the combinational part of the
// state feedback loop.
// Synchronous active-low reset loads the register defaults and clears all tracking state.
// An output stall holds the result register; the input register still takes one more
// event, and o_in_stall rises only when both registers are full.
module missing_tooth_trigger_decoder #(
    parameter int ERROR_WINDOW = 6,
    parameter int TIME_BITS    = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_edge_kind,
    input  logic [mtd_pkg::TS_W-1:0]       i_timestamp,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_synchronized,
    output logic [mtd_pkg::INDEX_W-1:0]    o_position_index,
    output logic                           o_cycle_start,
    output logic                           o_cycle_error,
    output logic                           o_decoder_fault,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mtd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mtd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mtd_pkg::*;

    t_cfg  cfg;
    t_item item;
    logic  item_valid;
    logic  adv;

    mtd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    mtd_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_edge_kind (i_edge_kind),
        .i_timestamp (i_timestamp),
        .i_adv       (adv),
        .o_valid     (item_valid),
        .o_item      (item)
    );

    mtd_decode #(
        .ERROR_WINDOW (ERROR_WINDOW),
        .TIME_BITS    (TIME_BITS)
    ) u_decode (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_valid          (item_valid),
        .i_item           (item),
        .o_adv            (adv),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_synchronized   (o_synchronized),
        .o_position_index (o_position_index),
        .o_cycle_start    (o_cycle_start),
        .o_cycle_error    (o_cycle_error),
        .o_decoder_fault  (o_decoder_fault)
    );

endmodule

>>> tb/missing_tooth_trigger_decoder_tb.sv
// Self-checking testbench for missing_tooth_trigger_decoder: directed table and randomized
// wheel phases, checked against the table for typed rows, else an in-bench predictor.
// Depends on mtd_pkg and the decoder RTL only.
`timescale 1ns / 100ps

module missing_tooth_trigger_decoder_tb;
    import mtd_pkg::*;

    localparam int HIST_W        = 6;
    localparam int CFG_REG_COUNT = 5;
    localparam int PHASES        = 16;
    localparam int PHASE_ITEMS   = 25;

    typedef struct packed {
        logic               sync;
        logic [INDEX_W-1:0] idx;
        logic               start;
        logic               err;
        logic               fault;
    } res_t;

    typedef struct {
        logic [1:0]      kind;
        logic [TS_W-1:0] ts;
        bit              typed;
        res_t            want;
    } stim_row_t;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    logic [1:0]            edge_kind  = '0;
    logic [TS_W-1:0]       timestamp  = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    logic                  out_sync;
    logic [INDEX_W-1:0]    out_index;
    logic                  out_start;
    logic                  out_err;
    logic                  out_fault;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;

    // predictor copy of the registers and tracking state
    logic                cf_rise;
    logic                cf_single;
    logic [EVENTS_W-1:0] cf_events;
    logic [RATIO_W-1:0]  cf_gap_lo;
    logic [RATIO_W-1:0]  cf_gap_hi;
    logic                st_synced;
    logic [INDEX_W-1:0]  st_index;
    logic [TS_W-1:0]     st_last_ts;
    logic [TS_W-1:0]     st_last_period;
    logic [HIST_W-1:0]   st_err_hist;

    res_t      result_q[$];
    stim_row_t stim_rows[$];
    bit        idle_on = 1'b1;
    int        n_mism = 0;
    int        n_sent = 0;
    int        n_checked = 0;
    int        n_starts = 0;
    int        n_faults = 0;
    res_t      want, got;

    missing_tooth_trigger_decoder dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_edge_kind     (edge_kind),
        .i_timestamp     (timestamp),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_synchronized  (out_sync),
        .o_position_index(out_index),
        .o_cycle_start   (out_start),
        .o_cycle_error   (out_err),
        .o_decoder_fault (out_fault),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic void bump_index();
        if (st_index != INDEX_MAX) st_index = st_index + 1'b1;
    endfunction

    // Advance the decoder state by one edge event and return the result it produces.
    function automatic res_t decode_edge(input logic [1:0] kind, input logic [TS_W-1:0] ts);
        res_t                r;
        logic [EVENTS_W-1:0] last_exp;
        logic [TS_W-1:0]     period;
        logic [63:0]         scaled, lo_bound, hi_bound;
        bit                  primary, hit;
        r = '0;
        last_exp = cf_events - 1'b1;
        primary = cf_rise ? (kind == EDGE_PRI_RISE) : (kind == EDGE_PRI_FALL);
        if (!primary) begin
            bump_index();
        end else begin
            period = ts - st_last_ts;
            if (cf_single) begin
                hit = !st_synced || (st_index == INDEX_W'(last_exp));
            end else begin
                // exact products, 40-bit period vs 48-bit bounds
                scaled   = 64'(period) << RATIO_FRAC;
                lo_bound = 64'(st_last_period) * 64'(cf_gap_lo);
                hi_bound = 64'(st_last_period) * 64'(cf_gap_hi);
                hit = (scaled > lo_bound) && (scaled < hi_bound);
            end
            if (hit) begin
                r.err       = (st_index != INDEX_W'(last_exp));
                st_err_hist = {st_err_hist[HIST_W-2:0], r.err};
                st_synced   = 1'b1;
                st_index    = '0;
                r.start     = 1'b1;
                n_starts++;
            end else begin
                bump_index();
            end
            st_last_period = period;
            st_last_ts     = ts;
        end
        r.sync  = st_synced;
        r.idx   = st_index;
        r.fault = ($countones(st_err_hist) > FAULT_LIMIT);
        return r;
    endfunction

    task automatic send_edge(input logic [1:0] kind, input logic [TS_W-1:0] ts,
                             input bit typed, input res_t typed_res);
        int   gap;
        res_t r;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        edge_kind <= kind;
        timestamp <= ts;
        do @(posedge clk); while (in_stall);
        r = decode_edge(kind, ts);
        if (typed) r = typed_res;
        if (r.fault) n_faults++;
        result_q.push_back(r);
        n_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_USE_RISING:   cf_rise   = data[0];
            CFG_SINGLE_TOOTH: cf_single = data[0];
            CFG_EVENTS:       cf_events = data[EVENTS_W-1:0];
            CFG_GAP_LOW:      cf_gap_lo = data[RATIO_W-1:0];
            CFG_GAP_HIGH:     cf_gap_hi = data[RATIO_W-1:0];
            default: ;
        endcase
    endtask

    // Stop sending and wait until every predicted result has been seen.
    task automatic drain();
        in_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic add_row(input logic [1:0] kind, input logic [TS_W-1:0] ts, input bit typed,
                           input logic s, input int idx, input logic st, input logic e,
                           input logic f);
        stim_row_t row;
        row.kind       = kind;
        row.ts         = ts;
        row.typed      = typed;
        row.want.sync  = s;
        row.want.idx   = INDEX_W'(idx);
        row.want.start = st;
        row.want.err   = e;
        row.want.fault = f;
        stim_rows.push_back(row);
    endtask

    // receiver: random stall before each result while idle_on is set
    initial begin
        int k;
        forever begin
            k = idle_on ? $urandom_range(0, 7) : 0;
            if (k > 0) begin
                out_stall <= 1'b1;
                repeat (k) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            got = {out_sync, out_index, out_start, out_err, out_fault};
            if (result_q.size() == 0) begin
                if (n_mism < 10)
                    $display("unexpected result at %0t: index %0d", $realtime, out_index);
                n_mism++;
            end else begin
                want = result_q.pop_front();
                n_checked++;
                if (got.sync !== want.sync || got.idx !== want.idx || got.start !== want.start ||
                    got.err !== want.err || got.fault !== want.fault) begin
                    if (n_mism < 10)
                        $display("mismatch at %0t (exp/act): sync %b/%b index %0d/%0d ",
                                 $realtime, want.sync, got.sync, want.idx, got.idx,
                                 "start %b/%b error %b/%b fault %b/%b",
                                 want.start, got.start, want.err, got.err,
                                 want.fault, got.fault);
                    n_mism++;
                end
            end
        end
    end

    initial begin
        int               ph, i, sent, teeth, per;
        bit               rise, single, wheel;
        logic [15:0]      ev, lo, hi;
        logic [TS_W-1:0]  t;
        t_edge_kind       prim, other;

        cf_rise        = RST_USE_RISING;
        cf_single      = RST_SINGLE_TOOTH;
        cf_events      = RST_EVENTS;
        cf_gap_lo      = RST_GAP_LOW;
        cf_gap_hi      = RST_GAP_HIGH;
        st_synced      = 1'b0;
        st_index       = '0;
        st_last_ts     = '0;
        st_last_period = '0;
        st_err_hist    = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset settings: rising primary, 116 events, gap 1.5..3.
        add_row(EDGE_SEC_RISE, 32'd0,        1, 0, 1, 0, 0, 0);
        add_row(EDGE_PRI_FALL, 32'd5,        1, 0, 2, 0, 0, 0);  // not the timing edge
        add_row(EDGE_SEC_FALL, 32'd7,        1, 0, 3, 0, 0, 0);
        add_row(EDGE_PRI_RISE, 32'd1000,     1, 0, 4, 0, 0, 0);  // previous period zero
        add_row(EDGE_PRI_RISE, 32'd2000,     1, 0, 5, 0, 0, 0);
        add_row(EDGE_PRI_RISE, 32'd4000,     1, 1, 0, 1, 1, 0);  // gap, wrong count
        add_row(EDGE_PRI_RISE, 32'd4000,     1, 1, 1, 0, 0, 0);  // zero period
        add_row(EDGE_PRI_RISE, 32'd5000,     1, 1, 2, 0, 0, 0);  // after zero period
        add_row(EDGE_PRI_RISE, 32'd6500,     1, 1, 3, 0, 0, 0);  // exactly low bound
        add_row(EDGE_PRI_RISE, 32'd11000,    1, 1, 4, 0, 0, 0);  // exactly high bound
        add_row(EDGE_PRI_RISE, 32'hFFFFFFFF, 1, 1, 5, 0, 0, 0);
        add_row(EDGE_PRI_RISE, 32'd100,      1, 1, 6, 0, 0, 0);  // timestamp wrap
        // short/long period pairs: repeated bad syncs drive the fault flag up
        add_row(EDGE_PRI_RISE, 32'd300,      0, 0, 0, 0, 0, 0);
        add_row(EDGE_PRI_RISE, 32'd400,      0, 0, 0, 0, 0, 0);
        add_row(EDGE_PRI_RISE, 32'd600,      0, 0, 0, 0, 0, 0);
        add_row(EDGE_PRI_RISE, 32'd700,      0, 0, 0, 0, 0, 0);
        add_row(EDGE_PRI_RISE, 32'd900,      0, 0, 0, 0, 0, 0);
        add_row(EDGE_PRI_RISE, 32'd1000,     0, 0, 0, 0, 0, 0);
        add_row(EDGE_PRI_RISE, 32'd1200,     0, 0, 0, 0, 0, 0);
        add_row(EDGE_SEC_FALL, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0);
        add_row(EDGE_PRI_FALL, 32'd0,        0, 0, 0, 0, 0, 0);
        foreach (stim_rows[r])
            send_edge(stim_rows[r].kind, stim_rows[r].ts, stim_rows[r].typed, stim_rows[r].want);
        drain();

        for (ph = 0; ph < PHASES; ph++) begin
            teeth  = $urandom_range(2, 8);
            rise   = 1'($urandom_range(0, 1));
            single = ($urandom_range(0, 3) == 0);
            wheel  = 1'b1;
            lo     = 16'd384;
            hi     = 16'd768;
            if (single) teeth = 1;
            ev = 16'(2 * teeth);
            case (ph)
                0: begin lo = 16'h0000; hi = 16'hFFFF; single = 1'b0; end
                1: begin lo = 16'hFFFF; hi = 16'h0000; single = 1'b0; end
                2: ev = 16'h0000;                           // last index wraps to 8191
                3: begin single = 1'b1; teeth = 1; ev = 16'hE002; end
                4: ev = 16'd4096;
                5: ev = 16'd1;
                6, 7: wheel = 1'b0;
                8: begin lo = 16'($urandom); hi = 16'($urandom); end
                default: ;
            endcase
            idle_on = 1'b1;
            write_reg(CFG_USE_RISING,   {15'($urandom), rise});
            write_reg(CFG_SINGLE_TOOTH, {15'($urandom), single});
            write_reg(CFG_EVENTS,       ev | (16'($urandom) & 16'hE000));
            write_reg(CFG_GAP_LOW,      lo);
            write_reg(CFG_GAP_HIGH,     hi);
            write_reg(CFG_IDX_W'(CFG_REG_COUNT + $urandom_range(0, 2)), 16'($urandom));

            idle_on = ($urandom_range(0, 3) != 0);
            prim  = rise ? EDGE_PRI_RISE : EDGE_PRI_FALL;
            other = rise ? EDGE_PRI_FALL : EDGE_PRI_RISE;
            per   = $urandom_range(16, 4000);
            t     = $urandom;
            sent  = 0;
            while (sent < PHASE_ITEMS) begin
                if (!wheel) begin
                    send_edge(2'($urandom_range(0, 3)), $urandom, 0, '0);
                    sent++;
                end else begin
                    for (i = 0; i < teeth && sent < PHASE_ITEMS; i++) begin
                        // tooth 0 follows the missing tooth: double period
                        t += ((i == 0 && !single) ? 2 * per : per) + $urandom_range(0, per / 16);
                        send_edge(prim, t, 0, '0);
                        send_edge(other, t + 32'(per / 2), 0, '0);
                        sent += 2;
                        if ($urandom_range(0, 15) == 0) begin
                            send_edge(2'($urandom_range(0, 3)), $urandom, 0, '0);
                            sent++;
                        end
                    end
                end
            end
            drain();
        end

        repeat (10) @(posedge clk);
        $display("run covered %0d edge events (%0d checked) over %0d register settings",
                 n_sent, n_checked, PHASES + 1);
        $display("predicted %0d cycle starts, %0d results with the fault flag set",
                 n_starts, n_faults);
        if (n_mism == 0 && result_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> missing_tooth_trigger_decoder.f
src/mtd_pkg.sv
src/mtd_cfg_regs.sv
src/mtd_in_stage.sv
src/mtd_decode.sv
src/missing_tooth_trigger_decoder.sv
tb/missing_tooth_trigger_decoder_tb.sv
